FILE: rtl/cmdp_pkg.sv
`default_nettype none

package cmdp_pkg;

  // Field widths of the channels and registers.
  localparam int OP_W       = 3;
  localparam int FREQ_W     = 48;
  localparam int MODE_W     = 2;
  localparam int SRC_W      = 2;
  localparam int PRESC_W    = 3;
  localparam int MOD_W      = 16;
  localparam int BASE_W     = 28;
  localparam int SLOW_W     = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  // Fixed-point format and the fixed low-rate source.
  localparam int FRAC_BITS     = 16;
  localparam int SPAN_BITS     = 16;
  localparam int LOW_SOURCE_HZ = 31250;

  // Datapath widths of the setup sequencer.
  localparam int CLAMP_W    = SLOW_W + FRAC_BITS;
  localparam int NUM1_W     = BASE_W + FRAC_BITS + 1;
  localparam int R_W        = NUM1_W;
  localparam int Q2_W       = BASE_W + FRAC_BITS;
  localparam int DIV1_STEPS = MOD_W + 2;
  localparam int DS_A_W     = CLAMP_W + DIV1_STEPS;
  localparam int DS_B_W     = MOD_W + Q2_W - 1;
  localparam int DS_W       = (DS_A_W > DS_B_W) ? DS_A_W : DS_B_W;
  localparam int STEP_W     = $clog2(Q2_W);

  localparam logic [MOD_W-1:0]   MOD_LIMIT   = 16'hFFFE;
  localparam logic [MOD_W-1:0]   RST_MODULUS = 16'd599;
  localparam logic [PRESC_W-1:0] PRESC_LAST  = 3'd6;
  localparam logic [PRESC_W-1:0] PRESC_MAX   = 3'd7;

  // Reset values of the registers.
  localparam logic [BASE_W-1:0] RST_BUS_HZ      = 28'd60000000;
  localparam logic [SLOW_W-1:0] RST_SLOW_MAX_HZ = 27'd8000000;
  localparam logic [BASE_W-1:0] RST_FAST_HZ     = 28'd20000000;
  localparam logic [FREQ_W-1:0] RST_SLOW_FREQ   = FREQ_W'(100000) << FRAC_BITS;

  typedef enum logic [MODE_W-1:0] {
    MODE_FAST  = 2'd0,
    MODE_SLOW  = 2'd1,
    MODE_SUPER = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef enum logic [OP_W-1:0] {
    OP_INDEP  = 3'd0,
    OP_SUPER  = 3'd1,
    OP_STOP   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUS_HZ   = 2'd0,
    REG_SLOW_MAX = 2'd1,
    REG_FAST_HZ  = 2'd2
  } reg_idx_t;

  localparam logic [SRC_W-1:0] SRC_BUS = 2'd1;
  localparam logic [SRC_W-1:0] SRC_LOW = 2'd2;

  // Smallest q with q * 2^SPAN_BITS >= hz in fixed point.
  function automatic logic [FREQ_W-1:0] span_threshold(input logic [BASE_W-1:0] hz);
    logic [BASE_W+FRAC_BITS:0] x;
    x = (BASE_W + FRAC_BITS + 1)'(hz) << FRAC_BITS;
    x = x + (BASE_W + FRAC_BITS + 1)'((1 << SPAN_BITS) - 1);
    return FREQ_W'(x >> SPAN_BITS);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cmdp_cmd_if.sv
`default_nettype none

// Command channel: operation code and requested frequency.
interface cmdp_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [cmdp_pkg::OP_W-1:0]    operation;
  logic [cmdp_pkg::FREQ_W-1:0]  request_freq;

  modport source (output valid, output operation, output request_freq, input ready);
  modport sink   (input valid, input operation, input request_freq, output ready);
endinterface

`default_nettype wire

FILE: rtl/cmdp_res_if.sv
`default_nettype none

// Result channel: clock mode and timer programming.
interface cmdp_res_if;
  logic                          valid;
  logic                          ready;
  logic [cmdp_pkg::MODE_W-1:0]   mode;
  logic                          runs_alone;
  logic [cmdp_pkg::SRC_W-1:0]    source_select;
  logic [cmdp_pkg::PRESC_W-1:0]  prescale_out;
  logic [cmdp_pkg::MOD_W-1:0]    modulus_out;
  logic [cmdp_pkg::MOD_W-1:0]    compare_out;
  logic [cmdp_pkg::FREQ_W-1:0]   reported_freq;
  logic [cmdp_pkg::FREQ_W-1:0]   requested_out;

  modport source (output valid, output mode, output runs_alone, output source_select,
                  output prescale_out, output modulus_out, output compare_out,
                  output reported_freq, output requested_out, input ready);
  modport sink   (input valid, input mode, input runs_alone, input source_select,
                  input prescale_out, input modulus_out, input compare_out,
                  input reported_freq, input requested_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/cmdp_cfg_if.sv
`default_nettype none

// Register write channel.
interface cmdp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cmdp_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [cmdp_pkg::CFG_DATA_W-1:0]   wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/clock_mode_divider_planner.sv
// Channel   Direction  Handshake     Payload
// cmd       in         valid/ready   operation, request_freq
// res       out        valid/ready   mode, runs_alone, source_select, prescale_out,
//                                    modulus_out, compare_out, reported_freq,
//                                    requested_out
// cfg       in         valid/ready   reg_index, wr_data (always ready)
//
// A command that needs no timer setup goes from acceptance through the decode and done
// states into the output register.
// A command with timer setup passes through decode, source choice, up to seven prescale
// tests, an 18-step modulus division and a fix-up step (both skipped when the modulus is
// set directly), a load step, a 44-step frequency division and the output step; both
// divisions share one restoring divider that retires one quotient bit per cycle.
// One command is worked on at a time; a new one is taken as soon as the
// previous result sits in the output register, and a stalled result holds the block.
// Reset is synchronous, active high.
`default_nettype none

module clock_mode_divider_planner (
  input  wire logic        clk,
  input  wire logic        rst,
  cmdp_cmd_if.sink         cmd,
  cmdp_res_if.source       res,
  cmdp_cfg_if.sink         cfg
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SOURCE,
    ST_PRESC,
    ST_MODSET,
    ST_DIVA,
    ST_MODFIX,
    ST_DIVB_LOAD,
    ST_DIVB,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [cmdp_pkg::BASE_W-1:0] bus_clock_hz;
  logic [cmdp_pkg::SLOW_W-1:0] slow_max_hz;
  logic [cmdp_pkg::BASE_W-1:0] fast_clock_hz;

  // Architectural state.
  cmdp_pkg::mode_t              cur_mode;
  cmdp_pkg::mode_t              saved_mode;
  cmdp_pkg::mode_t              pend_mode;
  logic [cmdp_pkg::FREQ_W-1:0]  requested_freq;
  logic [cmdp_pkg::FREQ_W-1:0]  achieved_freq;
  logic [cmdp_pkg::SRC_W-1:0]   source_sel;
  logic [cmdp_pkg::PRESC_W-1:0] prescale;
  logic [cmdp_pkg::MOD_W-1:0]   modulus;

  // Command and setup working registers.
  cmdp_pkg::op_t                 op_r;
  logic [cmdp_pkg::FREQ_W-1:0]   freq_r;
  logic [cmdp_pkg::CLAMP_W-1:0]  work_f;
  logic [cmdp_pkg::BASE_W-1:0]   bp;
  logic [cmdp_pkg::R_W-1:0]      rem;
  logic [cmdp_pkg::DS_W-1:0]     dsh;
  logic [cmdp_pkg::Q2_W-1:0]     quo;
  logic [cmdp_pkg::STEP_W-1:0]   step_cnt;

  // Decoder outputs.
  logic                          dec_setup;
  logic                          dec_save;
  logic [cmdp_pkg::FREQ_W-1:0]   dec_freq;
  cmdp_pkg::mode_t               dec_mode;

  // Datapath signals.
  logic [cmdp_pkg::FREQ_W-1:0]       fmax;
  logic [cmdp_pkg::CLAMP_W-1:0]      clamped;
  logic [cmdp_pkg::FREQ_W-1:0]       f_ext;
  logic                              low_src;
  logic                              presc_hit;
  logic [cmdp_pkg::NUM1_W-1:0]       num1;
  logic [cmdp_pkg::NUM1_W-1:0]       f_num;
  logic                              div_ge;
  logic [cmdp_pkg::R_W-1:0]          rem_sub;
  logic [cmdp_pkg::Q2_W-1:0]         quo_next;
  logic [cmdp_pkg::DIV1_STEPS-1:0]   q1;
  logic [cmdp_pkg::MOD_W-1:0]        mod_from_q;
  logic [cmdp_pkg::MOD_W-1:0]        den;
  logic [cmdp_pkg::NUM1_W-1:0]       num2;
  logic [cmdp_pkg::FREQ_W-1:0]       report;
  logic                              indep_nop;
  logic                              out_free;

  assign cmd.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free  = !res.valid || res.ready;

  assign fmax  = cmdp_pkg::FREQ_W'(slow_max_hz) << cmdp_pkg::FRAC_BITS;
  assign f_ext = cmdp_pkg::FREQ_W'(work_f);

  // Command decoding: target mode and whether a timer setup is needed.
  assign indep_nop = (freq_r == '0 && cur_mode == cmdp_pkg::MODE_STOP)
                  || (freq_r == requested_freq && cur_mode == cmdp_pkg::MODE_SLOW)
                  || (freq_r > fmax && cur_mode == cmdp_pkg::MODE_FAST);

  always_comb begin
    dec_setup = 1'b0;
    dec_save  = 1'b0;
    dec_freq  = freq_r;
    dec_mode  = cur_mode;
    case (op_r)
      cmdp_pkg::OP_INDEP: begin
        if (!indep_nop) begin
          if (freq_r == '0) begin
            dec_mode = cmdp_pkg::MODE_STOP;
          end else if (freq_r > fmax) begin
            dec_mode = cmdp_pkg::MODE_FAST;
          end else begin
            dec_mode  = cmdp_pkg::MODE_SLOW;
            dec_setup = 1'b1;
          end
        end
      end
      cmdp_pkg::OP_SUPER: begin
        if (!(freq_r == requested_freq && cur_mode == cmdp_pkg::MODE_SUPER)) begin
          dec_mode  = cmdp_pkg::MODE_SUPER;
          dec_setup = 1'b1;
        end
      end
      cmdp_pkg::OP_STOP: begin
        dec_mode = cmdp_pkg::MODE_STOP;
      end
      cmdp_pkg::OP_PAUSE: begin
        dec_save = 1'b1;
        dec_mode = cmdp_pkg::MODE_STOP;
      end
      cmdp_pkg::OP_RESUME: begin
        case (saved_mode)
          cmdp_pkg::MODE_SUPER: dec_mode = cmdp_pkg::MODE_SUPER;
          cmdp_pkg::MODE_FAST:  dec_mode = cmdp_pkg::MODE_FAST;
          cmdp_pkg::MODE_SLOW: begin
            dec_mode  = cmdp_pkg::MODE_SLOW;
            dec_setup = 1'b1;
            dec_freq  = requested_freq;
          end
          default: dec_mode = cur_mode;
        endcase
      end
      default: dec_mode = cur_mode;
    endcase
  end

  // Clamp to the slow maximum, then source choice and prescale test.
  assign clamped   = (dec_freq >= fmax) ? fmax[cmdp_pkg::CLAMP_W-1:0]
                                        : dec_freq[cmdp_pkg::CLAMP_W-1:0];
  assign low_src   = f_ext < cmdp_pkg::span_threshold(bus_clock_hz >> 7);
  assign presc_hit = f_ext >= cmdp_pkg::span_threshold(bp);

  // Modulus numerator, twice the scaled base.
  assign num1  = cmdp_pkg::NUM1_W'(bp) << (cmdp_pkg::FRAC_BITS + 1);
  assign f_num = cmdp_pkg::NUM1_W'(work_f);

  // One restoring division step, shared by both divisions.
  assign div_ge   = cmdp_pkg::DS_W'(rem) >= dsh;
  assign rem_sub  = rem - dsh[cmdp_pkg::R_W-1:0];
  assign quo_next = {quo[cmdp_pkg::Q2_W-2:0], div_ge};

  // Odd modulus, saturated at the limit.
  assign q1         = quo[cmdp_pkg::DIV1_STEPS-1:0];
  assign mod_from_q = (q1 >= cmdp_pkg::DIV1_STEPS'(cmdp_pkg::MOD_LIMIT))
                    ? cmdp_pkg::MOD_LIMIT
                    : (q1[cmdp_pkg::MOD_W-1:0] | cmdp_pkg::MOD_W'(1));

  // Achieved-frequency numerator, rounded to nearest.
  assign den  = modulus + cmdp_pkg::MOD_W'(1);
  assign num2 = (cmdp_pkg::NUM1_W'(bp) << cmdp_pkg::FRAC_BITS)
              + cmdp_pkg::NUM1_W'(den >> 1);

  // Frequency shown for the mode being entered.
  always_comb begin
    case (pend_mode)
      cmdp_pkg::MODE_FAST: report = cmdp_pkg::FREQ_W'(fast_clock_hz) << cmdp_pkg::FRAC_BITS;
      cmdp_pkg::MODE_STOP: report = '0;
      default:             report = achieved_freq;
    endcase
  end

  // Sequencer, state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      bus_clock_hz   <= cmdp_pkg::RST_BUS_HZ;
      slow_max_hz    <= cmdp_pkg::RST_SLOW_MAX_HZ;
      fast_clock_hz  <= cmdp_pkg::RST_FAST_HZ;
      cur_mode       <= cmdp_pkg::MODE_STOP;
      saved_mode     <= cmdp_pkg::MODE_FAST;
      pend_mode      <= cmdp_pkg::MODE_STOP;
      requested_freq <= cmdp_pkg::RST_SLOW_FREQ;
      achieved_freq  <= cmdp_pkg::RST_SLOW_FREQ;
      source_sel     <= cmdp_pkg::SRC_BUS;
      prescale       <= '0;
      modulus        <= cmdp_pkg::RST_MODULUS;
      res.valid      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.reg_index)
          cmdp_pkg::REG_BUS_HZ:   bus_clock_hz  <= cfg.wr_data;
          cmdp_pkg::REG_SLOW_MAX: slow_max_hz   <= cfg.wr_data[cmdp_pkg::SLOW_W-1:0];
          cmdp_pkg::REG_FAST_HZ:  fast_clock_hz <= cfg.wr_data;
          default: ;
        endcase
      end

      // A taken result clears the output register unless a new one replaces it.
      if (res.valid && res.ready && state != ST_DONE) begin
        res.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            op_r   <= cmdp_pkg::op_t'(cmd.operation);
            freq_r <= cmd.request_freq;
            state  <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          pend_mode <= dec_mode;
          work_f    <= clamped;
          if (dec_save) begin
            saved_mode <= cur_mode;
          end
          state <= dec_setup ? ST_SOURCE : ST_DONE;
        end
        ST_SOURCE: begin
          source_sel <= low_src ? cmdp_pkg::SRC_LOW : cmdp_pkg::SRC_BUS;
          bp         <= low_src ? cmdp_pkg::BASE_W'(cmdp_pkg::LOW_SOURCE_HZ) : bus_clock_hz;
          prescale   <= '0;
          state      <= ST_PRESC;
        end
        ST_PRESC: begin
          // One prescale tried per cycle; the base halves as it advances.
          if (presc_hit) begin
            state <= ST_MODSET;
          end else begin
            bp <= bp >> 1;
            if (prescale == cmdp_pkg::PRESC_LAST) begin
              prescale <= cmdp_pkg::PRESC_MAX;
              state    <= ST_MODSET;
            end else begin
              prescale <= prescale + cmdp_pkg::PRESC_W'(1);
            end
          end
        end
        ST_MODSET: begin
          if (work_f == '0) begin
            modulus <= cmdp_pkg::MOD_LIMIT;
            state   <= ST_DIVB_LOAD;
          end else if (num1 < f_num) begin
            modulus <= cmdp_pkg::MOD_W'(1);
            state   <= ST_DIVB_LOAD;
          end else begin
            rem      <= num1 - f_num;
            dsh      <= cmdp_pkg::DS_W'(work_f) << cmdp_pkg::DIV1_STEPS;
            quo      <= '0;
            step_cnt <= cmdp_pkg::STEP_W'(cmdp_pkg::DIV1_STEPS - 1);
            state    <= ST_DIVA;
          end
        end
        ST_DIVA: begin
          if (div_ge) begin
            rem <= rem_sub;
          end
          quo      <= quo_next;
          dsh      <= dsh >> 1;
          step_cnt <= step_cnt - cmdp_pkg::STEP_W'(1);
          if (step_cnt == '0) begin
            state <= ST_MODFIX;
          end
        end
        ST_MODFIX: begin
          modulus <= mod_from_q;
          state   <= ST_DIVB_LOAD;
        end
        ST_DIVB_LOAD: begin
          rem      <= num2;
          dsh      <= cmdp_pkg::DS_W'(den) << (cmdp_pkg::Q2_W - 1);
          quo      <= '0;
          step_cnt <= cmdp_pkg::STEP_W'(cmdp_pkg::Q2_W - 1);
          state    <= ST_DIVB;
        end
        ST_DIVB: begin
          if (div_ge) begin
            rem <= rem_sub;
          end
          quo      <= quo_next;
          dsh      <= dsh >> 1;
          step_cnt <= step_cnt - cmdp_pkg::STEP_W'(1);
          if (step_cnt == '0) begin
            achieved_freq  <= cmdp_pkg::FREQ_W'(quo_next);
            requested_freq <= f_ext;
            state          <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Result leaves once the output register is free.
          if (out_free) begin
            cur_mode          <= pend_mode;
            res.valid         <= 1'b1;
            res.mode          <= pend_mode;
            res.runs_alone    <= (pend_mode == cmdp_pkg::MODE_FAST)
                              || (pend_mode == cmdp_pkg::MODE_SLOW);
            res.source_select <= source_sel;
            res.prescale_out  <= prescale;
            res.modulus_out   <= modulus;
            res.compare_out   <= cmdp_pkg::MOD_W'(1) + (modulus >> 1);
            res.reported_freq <= report;
            res.requested_out <= requested_freq;
            state             <= ST_IDLE;
          end else if (res.valid && res.ready) begin
            res.valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_clock_mode_divider_planner.sv
module tb_clock_mode_divider_planner;
  timeunit 1ns;
  timeprecision 1ps;

  // Register ranges used when choosing settings.
  localparam int unsigned BUS_MIN  = 1_000_000;
  localparam int unsigned BUS_MAX  = 250_000_000;
  localparam int unsigned SLOW_MIN = 1;
  localparam int unsigned SLOW_MAX = 125_000_000;
  localparam int unsigned FAST_MIN = 0;
  localparam int unsigned FAST_MAX = 250_000_000;

  localparam logic [cmdp_pkg::OP_W-1:0]   OP_CODE_TOP   = '1;
  localparam logic [cmdp_pkg::FREQ_W-1:0] FREQ_ALL_ONES = '1;

  localparam int ITEMS_PER_SETTING = 205;
  localparam int DRAIN_LIMIT       = 20000;
  localparam int SETTLE_CYCLES     = 8;

  // One expected timer plan, in the order of the result fields.
  typedef struct packed {
    cmdp_pkg::mode_t                mode;
    logic                           runs_alone;
    logic [cmdp_pkg::SRC_W-1:0]     src;
    logic [cmdp_pkg::PRESC_W-1:0]   presc;
    logic [cmdp_pkg::MOD_W-1:0]     modulus;
    logic [cmdp_pkg::MOD_W-1:0]     compare;
    logic [cmdp_pkg::FREQ_W-1:0]    reported;
    logic [cmdp_pkg::FREQ_W-1:0]    requested;
  } timer_plan_t;

  logic clk;
  logic rst;

  cmdp_cmd_if cmd_ch ();
  cmdp_res_if res_ch ();
  cmdp_cfg_if cfg_ch ();

  clock_mode_divider_planner u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the registers and the planner state.
  logic [cmdp_pkg::BASE_W-1:0]  m_bus;
  logic [cmdp_pkg::SLOW_W-1:0]  m_slow_max;
  logic [cmdp_pkg::BASE_W-1:0]  m_fast;
  cmdp_pkg::mode_t              m_mode;
  cmdp_pkg::mode_t              m_saved;
  logic [cmdp_pkg::FREQ_W-1:0]  m_req;
  logic [cmdp_pkg::FREQ_W-1:0]  m_ach;
  logic [cmdp_pkg::SRC_W-1:0]   m_src;
  logic [cmdp_pkg::PRESC_W-1:0] m_presc;
  logic [cmdp_pkg::MOD_W-1:0]   m_mod;

  timer_plan_t pending_plans[$];
  int n_errors  = 0;
  int gap_pct   = 0;
  int stall_pct = 0;

  // Free-running clock, 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [cmdp_pkg::FREQ_W-1:0] hz_to_fixed(input int unsigned hz);
    return cmdp_pkg::FREQ_W'(64'(hz) << cmdp_pkg::FRAC_BITS);
  endfunction

  function automatic logic [cmdp_pkg::FREQ_W-1:0] slow_limit_fixed();
    return cmdp_pkg::FREQ_W'(64'(m_slow_max) << cmdp_pkg::FRAC_BITS);
  endfunction

  // Lowest fixed-point frequency that a timer clocked at hz can still reach.
  function automatic logic [63:0] reach_limit(input logic [63:0] hz);
    return ((hz << cmdp_pkg::FRAC_BITS) + ((64'd1 << cmdp_pkg::SPAN_BITS) - 64'd1))
           >> cmdp_pkg::SPAN_BITS;
  endfunction

  task automatic reset_shadow();
    m_bus      = cmdp_pkg::RST_BUS_HZ;
    m_slow_max = cmdp_pkg::RST_SLOW_MAX_HZ;
    m_fast     = cmdp_pkg::RST_FAST_HZ;
    m_mode     = cmdp_pkg::MODE_STOP;
    m_saved    = cmdp_pkg::MODE_FAST;
    m_req      = cmdp_pkg::RST_SLOW_FREQ;
    m_ach      = cmdp_pkg::RST_SLOW_FREQ;
    m_src      = cmdp_pkg::SRC_BUS;
    m_presc    = '0;
    m_mod      = cmdp_pkg::RST_MODULUS;
  endtask

  // Works out source, prescaler, modulus and achieved frequency for a slow clock.
  function automatic void plan_slow_timer(input logic [cmdp_pkg::FREQ_W-1:0] freq);
    logic [63:0] f;
    logic [63:0] fmax;
    logic [63:0] base;
    logic [63:0] scaled;
    logic [63:0] num;
    logic [63:0] md;
    logic [63:0] den;
    int unsigned p;
    fmax = 64'(m_slow_max) << cmdp_pkg::FRAC_BITS;
    f = 64'(freq);
    if (f >= fmax) begin
      f = fmax;
    end
    // The low source is used when even the deepest bus prescale overshoots.
    if (f < reach_limit(64'(m_bus) >> cmdp_pkg::PRESC_MAX)) begin
      m_src = cmdp_pkg::SRC_LOW;
      base  = 64'(cmdp_pkg::LOW_SOURCE_HZ);
    end else begin
      m_src = cmdp_pkg::SRC_BUS;
      base  = 64'(m_bus);
    end
    p = 0;
    while (p < cmdp_pkg::PRESC_MAX && f < reach_limit(base >> p)) begin
      p++;
    end
    scaled = base >> p;
    if (f == 0) begin
      md = 64'(cmdp_pkg::MOD_LIMIT);
    end else begin
      num = scaled << (cmdp_pkg::FRAC_BITS + 1);
      if (num < f) begin
        md = 0;
      end else begin
        md = (num - f) / (f << 1);
      end
      md = md | 64'd1;
      if (md > 64'(cmdp_pkg::MOD_LIMIT)) begin
        md = 64'(cmdp_pkg::MOD_LIMIT);
      end
    end
    den     = md + 64'd1;
    m_presc = cmdp_pkg::PRESC_W'(p);
    m_mod   = cmdp_pkg::MOD_W'(md);
    m_ach   = cmdp_pkg::FREQ_W'(((scaled << cmdp_pkg::FRAC_BITS) + (den >> 1)) / den);
    m_req   = cmdp_pkg::FREQ_W'(f);
  endfunction

  // Applies one command to the shadow state and returns the plan it reports.
  function automatic timer_plan_t apply_command(input logic [cmdp_pkg::OP_W-1:0] op,
                                                input logic [cmdp_pkg::FREQ_W-1:0] freq);
    timer_plan_t plan;
    logic [cmdp_pkg::FREQ_W-1:0] fmax;
    logic ignored;
    fmax = slow_limit_fixed();
    case (op)
      cmdp_pkg::OP_INDEP: begin
        ignored = (freq == 0 && m_mode == cmdp_pkg::MODE_STOP) ||
                  (freq == m_req && m_mode == cmdp_pkg::MODE_SLOW) ||
                  (freq > fmax && m_mode == cmdp_pkg::MODE_FAST);
        if (!ignored) begin
          m_mode = cmdp_pkg::MODE_STOP;
          if (freq == 0) begin
            m_mode = cmdp_pkg::MODE_STOP;
          end else if (freq > fmax) begin
            m_mode = cmdp_pkg::MODE_FAST;
          end else begin
            plan_slow_timer(freq);
            m_mode = cmdp_pkg::MODE_SLOW;
          end
        end
      end
      cmdp_pkg::OP_SUPER: begin
        if (!(freq == m_req && m_mode == cmdp_pkg::MODE_SUPER)) begin
          plan_slow_timer(freq);
          m_mode = cmdp_pkg::MODE_SUPER;
        end
      end
      cmdp_pkg::OP_STOP: begin
        m_mode = cmdp_pkg::MODE_STOP;
      end
      cmdp_pkg::OP_PAUSE: begin
        m_saved = m_mode;
        m_mode  = cmdp_pkg::MODE_STOP;
      end
      cmdp_pkg::OP_RESUME: begin
        case (m_saved)
          cmdp_pkg::MODE_SUPER: m_mode = cmdp_pkg::MODE_SUPER;
          cmdp_pkg::MODE_FAST:  m_mode = cmdp_pkg::MODE_FAST;
          cmdp_pkg::MODE_SLOW: begin
            plan_slow_timer(m_req);
            m_mode = cmdp_pkg::MODE_SLOW;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    plan.mode       = m_mode;
    plan.runs_alone = (m_mode == cmdp_pkg::MODE_FAST || m_mode == cmdp_pkg::MODE_SLOW);
    plan.src        = m_src;
    plan.presc      = m_presc;
    plan.modulus    = m_mod;
    plan.compare    = cmdp_pkg::MOD_W'(17'd1 + 17'(m_mod >> 1));
    case (m_mode)
      cmdp_pkg::MODE_FAST:
        plan.reported = cmdp_pkg::FREQ_W'(64'(m_fast) << cmdp_pkg::FRAC_BITS);
      cmdp_pkg::MODE_STOP: plan.reported = '0;
      default:             plan.reported = m_ach;
    endcase
    plan.requested = m_req;
    return plan;
  endfunction

  // Offers one command, optionally after a few idle cycles, and records its plan.
  task automatic send_command(input logic [cmdp_pkg::OP_W-1:0] op,
                              input logic [cmdp_pkg::FREQ_W-1:0] freq);
    int idle_cycles;
    idle_cycles = 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      idle_cycles++;
    end
    if (idle_cycles > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (idle_cycles) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.operation    <= op;
    cmd_ch.request_freq <= freq;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    pending_plans.push_back(apply_command(op, freq));
  endtask

  // Stops offering commands until every outstanding plan has been reported or the drain limit runs out.
  task automatic wait_for_results();
    int waited;
    cmd_ch.valid <= 1'b0;
    waited = 0;
    while (pending_plans.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register and leaves the write channel valid for a following write.
  task automatic write_register(input cmdp_pkg::reg_idx_t idx,
                                input logic [cmdp_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    case (idx)
      cmdp_pkg::REG_BUS_HZ:   m_bus      = data[cmdp_pkg::BASE_W-1:0];
      cmdp_pkg::REG_SLOW_MAX: m_slow_max = data[cmdp_pkg::SLOW_W-1:0];
      cmdp_pkg::REG_FAST_HZ:  m_fast     = data[cmdp_pkg::BASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_registers(input int unsigned bus, input int unsigned slow,
                                 input int unsigned fast);
    write_register(cmdp_pkg::REG_BUS_HZ, cmdp_pkg::CFG_DATA_W'(bus));
    write_register(cmdp_pkg::REG_SLOW_MAX, cmdp_pkg::CFG_DATA_W'(slow));
    write_register(cmdp_pkg::REG_FAST_HZ, cmdp_pkg::CFG_DATA_W'(fast));
    cfg_ch.valid <= 1'b0;
  endtask

  // Picks a register setting, with the range ends chosen often.
  task automatic pick_registers();
    int unsigned bus;
    int unsigned slow;
    int unsigned fast;
    case ($urandom_range(0, 4))
      0:       bus = BUS_MIN;
      1:       bus = BUS_MAX;
      default: bus = $urandom_range(BUS_MIN, BUS_MAX);
    endcase
    case ($urandom_range(0, 4))
      0:       slow = SLOW_MIN;
      1:       slow = SLOW_MAX;
      default: slow = $urandom_range(SLOW_MIN, SLOW_MAX) >> $urandom_range(0, 16);
    endcase
    if (slow < SLOW_MIN) begin
      slow = SLOW_MIN;
    end
    case ($urandom_range(0, 4))
      0:       fast = FAST_MIN;
      1:       fast = FAST_MAX;
      default: fast = $urandom_range(FAST_MIN, FAST_MAX);
    endcase
    write_registers(bus, slow, fast);
  endtask

  function automatic logic [cmdp_pkg::OP_W-1:0] next_operation();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return cmdp_pkg::OP_INDEP;
    if (r < 60) return cmdp_pkg::OP_SUPER;
    if (r < 68) return cmdp_pkg::OP_STOP;
    if (r < 80) return cmdp_pkg::OP_PAUSE;
    if (r < 95) return cmdp_pkg::OP_RESUME;
    return cmdp_pkg::OP_W'($urandom_range(int'(cmdp_pkg::OP_RESUME) + 1,
                                          int'(OP_CODE_TOP)));
  endfunction

  // Requests aimed at the limits, the repeat rules and the prescale thresholds.
  function automatic logic [cmdp_pkg::FREQ_W-1:0] next_request();
    logic [63:0] wide;
    logic [63:0] base;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: return '0;
      1: return m_req;
      2: return slow_limit_fixed();
      3: return slow_limit_fixed() + cmdp_pkg::FREQ_W'(1);
      4: return wide[cmdp_pkg::FREQ_W-1:0];
      5, 6: begin
        base = $urandom_range(0, 1) ? 64'(m_bus) : 64'(cmdp_pkg::LOW_SOURCE_HZ);
        base = base >> $urandom_range(0, int'(cmdp_pkg::PRESC_MAX));
        return cmdp_pkg::FREQ_W'(base + 64'($urandom_range(0, 2)) - 64'd1);
      end
      default: return wide[cmdp_pkg::FREQ_W-1:0] >> $urandom_range(0, cmdp_pkg::FREQ_W - 1);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [cmdp_pkg::FREQ_W-1:0] want,
                             input logic [cmdp_pkg::FREQ_W-1:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Every accepted result transaction is compared with the oldest expected plan.
  always @(posedge clk) begin : check_results
    timer_plan_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_plans.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, expected none, actual mode %0d",
                 $time, res_ch.mode);
      end else begin
        want = pending_plans.pop_front();
        check_field("mode", cmdp_pkg::FREQ_W'(want.mode), cmdp_pkg::FREQ_W'(res_ch.mode));
        check_field("runs_alone", cmdp_pkg::FREQ_W'(want.runs_alone),
                    cmdp_pkg::FREQ_W'(res_ch.runs_alone));
        check_field("source_select", cmdp_pkg::FREQ_W'(want.src),
                    cmdp_pkg::FREQ_W'(res_ch.source_select));
        check_field("prescale_out", cmdp_pkg::FREQ_W'(want.presc),
                    cmdp_pkg::FREQ_W'(res_ch.prescale_out));
        check_field("modulus_out", cmdp_pkg::FREQ_W'(want.modulus),
                    cmdp_pkg::FREQ_W'(res_ch.modulus_out));
        check_field("compare_out", cmdp_pkg::FREQ_W'(want.compare),
                    cmdp_pkg::FREQ_W'(res_ch.compare_out));
        check_field("reported_freq", want.reported, res_ch.reported_freq);
        check_field("requested_out", want.requested, res_ch.requested_out);
      end
    end
  end

  // The receiver stalls at random while the current rate says so.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Mode changes, repeat rules, pause and resume under the reset register values.
  task automatic test_mode_commands();
    logic [cmdp_pkg::FREQ_W-1:0] edge_low;
    gap_pct   = 18;
    stall_pct = 62;
    edge_low  = cmdp_pkg::FREQ_W'(m_bus >> cmdp_pkg::PRESC_MAX);
    send_command(cmdp_pkg::OP_INDEP, '0);
    send_command(cmdp_pkg::OP_INDEP, slow_limit_fixed() + cmdp_pkg::FREQ_W'(1));
    send_command(cmdp_pkg::OP_INDEP, FREQ_ALL_ONES);
    send_command(cmdp_pkg::OP_PAUSE, FREQ_ALL_ONES);
    send_command(cmdp_pkg::OP_RESUME, '0);
    send_command(cmdp_pkg::OP_INDEP, hz_to_fixed(1_000_000));
    send_command(cmdp_pkg::OP_INDEP, hz_to_fixed(1_000_000));
    send_command(cmdp_pkg::OP_PAUSE, '0);
    send_command(cmdp_pkg::OP_RESUME, '0);
    // A zero supervised frequency saturates the modulus.
    send_command(cmdp_pkg::OP_SUPER, '0);
    send_command(cmdp_pkg::OP_SUPER, '0);
    send_command(cmdp_pkg::OP_SUPER, FREQ_ALL_ONES);
    send_command(cmdp_pkg::OP_PAUSE, '0);
    send_command(cmdp_pkg::OP_RESUME, '0);
    send_command(cmdp_pkg::OP_INDEP, cmdp_pkg::FREQ_W'(1));
    // Either side of the point where the low source takes over.
    send_command(cmdp_pkg::OP_SUPER, edge_low);
    send_command(cmdp_pkg::OP_SUPER, edge_low - cmdp_pkg::FREQ_W'(1));
    send_command(cmdp_pkg::OP_INDEP, slow_limit_fixed());
    send_command(cmdp_pkg::OP_STOP, '0);
    send_command(cmdp_pkg::OP_RESUME, '0);
    // Pausing while stopped leaves a later resume with nothing to do.
    send_command(cmdp_pkg::OP_STOP, '0);
    send_command(cmdp_pkg::OP_PAUSE, '0);
    send_command(cmdp_pkg::OP_RESUME, '0);
    send_command(OP_CODE_TOP, FREQ_ALL_ONES);
  endtask

  // Smallest and largest register values.
  task automatic test_register_extremes();
    wait_for_results();
    write_registers(BUS_MIN, SLOW_MIN, FAST_MIN);
    send_command(cmdp_pkg::OP_INDEP, hz_to_fixed(1));
    send_command(cmdp_pkg::OP_SUPER, cmdp_pkg::FREQ_W'(1));
    send_command(cmdp_pkg::OP_INDEP, FREQ_ALL_ONES);
    wait_for_results();
    write_registers(BUS_MAX, SLOW_MAX, FAST_MAX);
    send_command(cmdp_pkg::OP_SUPER, FREQ_ALL_ONES);
    send_command(cmdp_pkg::OP_INDEP, cmdp_pkg::FREQ_W'(1));
    send_command(cmdp_pkg::OP_INDEP, FREQ_ALL_ONES);
  endtask

  // Random commands under several register settings at the given idle rates.
  task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
    for (int s = 0; s < 3; s++) begin
      wait_for_results();
      pick_registers();
      gap_pct   = sender_idle;
      stall_pct = receiver_idle;
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        // Halfway through, hold off until the block has caught up.
        if (i == ITEMS_PER_SETTING / 2) begin
          wait_for_results();
        end
        send_command(next_operation(), next_request());
      end
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.operation    <= cmdp_pkg::OP_STOP;
    cmd_ch.request_freq <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.reg_index    <= cmdp_pkg::REG_BUS_HZ;
    cfg_ch.wr_data      <= '0;
    reset_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_mode_commands();
    test_register_extremes();
    test_random_traffic(18, 62);
    test_random_traffic(62, 18);
    test_random_traffic(0, 0);

    wait_for_results();
    if (pending_plans.size() != 0) begin
      n_errors++;
      $display("%0t: results never arrived, expected %0d more, actual 0",
               $time, pending_plans.size());
    end
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cmdp_pkg.sv
rtl/cmdp_cmd_if.sv
rtl/cmdp_res_if.sv
rtl/cmdp_cfg_if.sv
rtl/clock_mode_divider_planner.sv
verif/tb_clock_mode_divider_planner.sv
